/* src/pfma_pkg.sv */
// ----------------------------------------------------------------------------
// pfma_pkg: shared types and constants for the pooling block
// Sizes, register codes, beat payloads and the cell link record.
// ----------------------------------------------------------------------------
package pfma_pkg;

  localparam int MAX_WINDOW      = 8;
  localparam int WIN_BITS        = $clog2(MAX_WINDOW);
  localparam int MAX_FRAME_WIDTH = 1024;
  localparam int COL_BITS        = $clog2(MAX_FRAME_WIDTH);
  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_HEIGHT      = 1024;
  localparam int MAX_STEP        = 15;
  localparam int MAX_CHANNELS    = 64;
  localparam int ROW_BITS        = 10;
  localparam int CH_BITS         = 6;
  localparam int PART_BITS       = SAMPLE_BITS + 2 * WIN_BITS + 2;
  localparam int DIV_BITS        = SAMPLE_BITS + 2 * WIN_BITS;
  localparam int DVSR_BITS       = 7;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 11;
  localparam int MEM_DEPTH       = MAX_WINDOW * MAX_FRAME_WIDTH;
  localparam int MEM_ADDR_BITS   = WIN_BITS + COL_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_POOL_MODE     = 3'd0,
    REG_WINDOW_HEIGHT = 3'd1,
    REG_WINDOW_WIDTH  = 3'd2,
    REG_STEP_SIZE     = 3'd3,
    REG_FRAME_WIDTH   = 3'd4,
    REG_FRAME_HEIGHT  = 3'd5,
    REG_CHANNEL_COUNT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_start;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pooled_value;
    logic [ROW_BITS-1:0]           out_row;
    logic [COL_BITS-1:0]           out_col;
    logic [CH_BITS-1:0]            channel;
    logic                          frame_last;
  } out_t;

  // accumulator travelling down the cell row
  typedef struct packed {
    logic                        valid;
    logic                        has;
    logic signed [PART_BITS-1:0] acc;
  } link_t;

endpackage

/* src/pfma_cell.sv */
// ----------------------------------------------------------------------------
// pfma_cell: one column-partial cell
// Holds one vertical partial and folds it into the passing accumulator.
// ----------------------------------------------------------------------------
module pfma_cell import pfma_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic signed [PART_BITS-1:0] load_value,
  input  logic                        avg,
  input  logic                        sel,
  input  link_t                       link_in,
  output link_t                       link_out
);

  logic signed [PART_BITS-1:0] part;
  logic signed [PART_BITS-1:0] acc_next;

  always_comb begin
    if (!sel) begin
      acc_next = link_in.acc;
    end else if (!link_in.has) begin
      acc_next = part;
    end else if (avg) begin
      acc_next = link_in.acc + part;
    end else begin
      acc_next = (part > link_in.acc) ? part : link_in.acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part     <= '0;
      link_out <= '0;
    end else begin
      if (load) begin
        part <= load_value;
      end
      link_out.valid <= link_in.valid;
      link_out.has   <= link_in.has | sel;
      link_out.acc   <= acc_next;
    end
  end

endmodule

/* src/pfma_div.sv */
// ----------------------------------------------------------------------------
// pfma_div: serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with results.
// ----------------------------------------------------------------------------
module pfma_div import pfma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_BITS-1:0]  dividend,
  input  logic [DVSR_BITS-1:0] divisor,
  output logic                 done,
  output logic [DIV_BITS-1:0]  quotient,
  output logic [DVSR_BITS-1:0] remainder
);

  localparam int CNT_BITS = $clog2(DIV_BITS + 1);

  logic                busy;
  logic [CNT_BITS-1:0] count;
  logic [DVSR_BITS:0]  trial;
  logic [DVSR_BITS-1:0] dvsr;

  assign trial = {remainder, quotient[DIV_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == CNT_BITS'(1));
      if (start) begin
        busy      <= 1'b1;
        count     <= CNT_BITS'(DIV_BITS);
        quotient  <= dividend;
        remainder <= '0;
        dvsr      <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvsr}) begin
          remainder <= DVSR_BITS'(trial - {1'b0, dvsr});
          quotient  <= {quotient[DIV_BITS-2:0], 1'b1};
        end else begin
          remainder <= trial[DVSR_BITS-1:0];
          quotient  <= {quotient[DIV_BITS-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* src/pooling_forward_max_avg.sv */
// ----------------------------------------------------------------------------
// pooling_forward_max_avg: streaming 2-D max / average pooling
// Line store, a row of column-partial cells and a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one Q8.8 sample per beat in raster order,
//   channel after channel; frame_start marks the first sample of channel 0.
//   out_valid/out_stall/out_data carry one pooled result per beat, tagged with
//   output row, column, channel and a last-window-of-frame mark.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the seven control registers;
//   cfg_ready is always high. Write only while the block is idle.
// Sequence:
//   One sample at a time; in_stall is high until it is finished. A sample whose
//   row is above the first full window row is only stored. Otherwise the block
//   gathers the column from the line store (a read state and an accumulate
//   state per older row), then stores the column partial. A window end adds two
//   stride divisions (top, then left); a window on the stride grid then walks
//   the accumulator down the cell row, divides by the window area in average
//   mode and loads the output.
// Reset:
//   rst clears positions, partials and registers to their defaults. The line
//   store is not cleared; rows never written read as garbage.
// Back-pressure:
//   A finished result waits in the output register; the block keeps taking
//   samples until the next result finds the register still full, then holds.
// ----------------------------------------------------------------------------
module pooling_forward_max_avg import pfma_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_t                       in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_t                      out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_GREAD, S_GACC, S_COLW, S_DIVT, S_DIVL, S_CHAIN, S_DIVA, S_OUT
  } state_t;

  // control registers as written
  logic       pool_mode;
  logic [3:0] window_height, window_width, step_size;
  logic [10:0] frame_width, frame_height;
  logic [6:0] channel_count;

  // effective (clamped) values
  logic [3:0]  wh, ww, st;
  logic [10:0] fw, fh;
  logic [6:0]  cc;

  state_t state;
  logic [COL_BITS-1:0] col_pos, cur_c;
  logic [ROW_BITS-1:0] row_pos, cur_r;
  logic [CH_BITS-1:0]  ch_pos, cur_ch;
  logic [COL_BITS-1:0] c_eff, c_next;
  logic [ROW_BITS-1:0] r_eff, r_next;
  logic [CH_BITS-1:0]  ch_eff, ch_next;
  logic [3:0]          k;
  logic signed [PART_BITS-1:0] p, pv, x_ext;
  logic [ROW_BITS-1:0] top, q_top;
  logic [COL_BITS-1:0] left, q_left;
  logic                rem_top_zero, last, neg;
  logic signed [SAMPLE_BITS-1:0] result;
  logic                accept, out_accept;
  logic                div_go, chain_go, out_load;

  // line store
  logic [SAMPLE_BITS-1:0]   line_mem [MEM_DEPTH];
  logic [SAMPLE_BITS-1:0]   mem_q;
  logic [MEM_ADDR_BITS-1:0] rd_addr;
  logic [WIN_BITS-1:0]      rd_row;

  // divider
  logic                 div_start, div_done;
  logic [DIV_BITS-1:0]  div_dividend, div_quotient;
  logic [DVSR_BITS-1:0] div_divisor, div_remainder;

  // cell row
  link_t link [MAX_WINDOW+1];
  logic  chain_start;
  logic [7:0] area;
  logic [PART_BITS-1:0] mag;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // clamp registers: zero acts as one, oversize saturates
  always_comb begin
    wh = (window_height == 4'd0) ? 4'd1 :
         (window_height > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : window_height;
    ww = (window_width == 4'd0) ? 4'd1 :
         (window_width > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : window_width;
    st = (step_size == 4'd0) ? 4'd1 : step_size;
    fw = (frame_width == 11'd0) ? 11'd1 :
         (frame_width > 11'(MAX_FRAME_WIDTH)) ? 11'(MAX_FRAME_WIDTH) : frame_width;
    fh = (frame_height == 11'd0) ? 11'd1 :
         (frame_height > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : frame_height;
    cc = (channel_count == 7'd0) ? 7'd1 :
         (channel_count > 7'(MAX_CHANNELS)) ? 7'(MAX_CHANNELS) : channel_count;
  end

  // position of the arriving sample and of the one after it
  always_comb begin
    c_eff  = in_data.frame_start ? '0 : col_pos;
    r_eff  = in_data.frame_start ? '0 : row_pos;
    ch_eff = in_data.frame_start ? '0 : ch_pos;
    if ({1'b0, c_eff} >= fw) c_eff = '0;
    if ({1'b0, r_eff} >= fh) r_eff = '0;
    if ({1'b0, ch_eff} >= cc) ch_eff = '0;
    c_next  = COL_BITS'({1'b0, c_eff} + 11'd1);
    r_next  = r_eff;
    ch_next = ch_eff;
    if ({1'b0, c_eff} + 11'd1 >= fw) begin
      c_next = '0;
      r_next = ROW_BITS'({1'b0, r_eff} + 11'd1);
      if ({1'b0, r_eff} + 11'd1 >= fh) begin
        r_next  = '0;
        ch_next = CH_BITS'({1'b0, ch_eff} + 7'd1);
        if ({1'b0, ch_eff} + 7'd1 >= cc) ch_next = '0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode     <= 1'b0;
      window_height <= 4'd2;
      window_width  <= 4'd2;
      step_size     <= 4'd2;
      frame_width   <= 11'd1024;
      frame_height  <= 11'd1024;
      channel_count <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POOL_MODE:     pool_mode     <= cfg_data[0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[3:0];
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[3:0];
        REG_STEP_SIZE:     step_size     <= cfg_data[3:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // line store: write the arriving sample, read an older row of the current column
  assign rd_row  = cur_r[WIN_BITS-1:0] - k[WIN_BITS-1:0];
  assign rd_addr = {rd_row, cur_c};

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[{r_eff[WIN_BITS-1:0], c_eff}] <= in_data.sample;
    end
    mem_q <= line_mem[rd_addr];
  end

  assign pv    = PART_BITS'(signed'(mem_q));
  assign x_ext = PART_BITS'(in_data.sample);

  // cell row: accumulator enters at cell 0 and walks to the last cell
  assign link[0] = '{valid: chain_start, has: 1'b0, acc: '0};

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [WIN_BITS-1:0] offset;
    assign offset = cur_c[WIN_BITS-1:0] - WIN_BITS'(i);
    pfma_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .load       ((state == S_COLW) && (cur_c[WIN_BITS-1:0] == WIN_BITS'(i))),
      .load_value (p),
      .avg        (pool_mode),
      .sel        ({1'b0, offset} < ww),
      .link_in    (link[i]),
      .link_out   (link[i+1])
    );
  end

  pfma_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  assign area = wh * ww;
  assign mag  = link[MAX_WINDOW].acc[PART_BITS-1] ? -link[MAX_WINDOW].acc
                                                  : link[MAX_WINDOW].acc;

  // start a division at a window end, after the top division, and for the
  // area in average mode; launch the cell row once both strides divide evenly
  assign div_go   = ((state == S_COLW) && ({1'b0, cur_c} + 11'd1 >= {7'd0, ww})) ||
                    ((state == S_DIVT) && div_done) ||
                    ((state == S_CHAIN) && link[MAX_WINDOW].valid && pool_mode);
  assign chain_go = (state == S_DIVL) && div_done && rem_top_zero &&
                    (div_remainder == '0);
  assign out_load = (state == S_OUT) && (!out_valid || out_accept);

  // sequencer: gather column, store partial, check stride, combine, divide, output
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      col_pos     <= '0;
      row_pos     <= '0;
      ch_pos      <= '0;
      out_valid   <= 1'b0;
      div_start   <= 1'b0;
      chain_start <= 1'b0;
    end else begin
      div_start   <= div_go;
      chain_start <= chain_go;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_accept) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            col_pos <= c_next;
            row_pos <= r_next;
            ch_pos  <= ch_next;
            cur_c   <= c_eff;
            cur_r   <= r_eff;
            cur_ch  <= ch_eff;
            p       <= x_ext;
            k       <= 4'd1;
            if ({1'b0, r_eff} + 11'd1 >= {7'd0, wh}) begin
              state <= (wh == 4'd1) ? S_COLW : S_GREAD;
            end
          end
        end
        S_GREAD: begin
          state <= S_GACC;
        end
        S_GACC: begin
          if (pool_mode) begin
            p <= p + pv;
          end else if (pv > p) begin
            p <= pv;
          end
          if (k + 4'd1 < wh) begin
            k     <= k + 4'd1;
            state <= S_GREAD;
          end else begin
            state <= S_COLW;
          end
        end
        S_COLW: begin
          if ({1'b0, cur_c} + 11'd1 >= {7'd0, ww}) begin
            top          <= ROW_BITS'({1'b0, cur_r} + 11'd1 - {7'd0, wh});
            left         <= COL_BITS'({1'b0, cur_c} + 11'd1 - {7'd0, ww});
            div_dividend <= DIV_BITS'(ROW_BITS'({1'b0, cur_r} + 11'd1 - {7'd0, wh}));
            div_divisor  <= DVSR_BITS'(st);
            state        <= S_DIVT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIVT: begin
          if (div_done) begin
            q_top        <= div_quotient[ROW_BITS-1:0];
            rem_top_zero <= (div_remainder == '0);
            div_dividend <= DIV_BITS'(left);
            state        <= S_DIVL;
          end
        end
        S_DIVL: begin
          if (div_done) begin
            if (chain_go) begin
              q_left <= div_quotient[COL_BITS-1:0];
              last <= ({2'b0, top} + {8'd0, st} > {1'b0, fh} - {8'd0, wh}) &&
                      ({2'b0, left} + {8'd0, st} > {1'b0, fw} - {8'd0, ww});
              state  <= S_CHAIN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_CHAIN: begin
          if (link[MAX_WINDOW].valid) begin
            if (pool_mode) begin
              neg          <= link[MAX_WINDOW].acc[PART_BITS-1];
              div_dividend <= DIV_BITS'(mag);
              div_divisor  <= DVSR_BITS'(area);
              state        <= S_DIVA;
            end else begin
              result <= SAMPLE_BITS'(link[MAX_WINDOW].acc);
              state  <= S_OUT;
            end
          end
        end
        S_DIVA: begin
          if (div_done) begin
            result <= neg ? SAMPLE_BITS'(-div_quotient) : SAMPLE_BITS'(div_quotient);
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            out_data.pooled_value   <= result;
            out_data.out_row        <= q_top;
            out_data.out_col        <= q_left;
            out_data.channel        <= cur_ch;
            out_data.frame_last     <= last;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/pfma_checker.sv */
// ----------------------------------------------------------------------------
// pfma_checker: port-level checks for the pooling block
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module pfma_checker import pfma_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data,
  input logic cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without the block being busy");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present right after reset");

endmodule

bind pooling_forward_max_avg pfma_checker u_pfma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
